/* rtl/tfd_pkg.sv */
// shared types, codes and constants of the tunnel frame deframer
`default_nettype none

package tfd_pkg;

    localparam int HEADER_BYTES = 20;
    localparam int HDR_BITS     = HEADER_BYTES * 8;
    localparam int POS_W        = $clog2(HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(HEADER_BYTES - 1);

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = Q_AW + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 3'd4;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [2:0] ERR_MAGIC     = 3'd0;
    localparam logic [2:0] ERR_VERSION   = 3'd1;
    localparam logic [2:0] ERR_TYPE      = 3'd2;
    localparam logic [2:0] ERR_FLAGS     = 3'd3;
    localparam logic [2:0] ERR_TOO_LARGE = 3'd4;
    localparam logic [2:0] ERR_FAILED    = 3'd5;

    localparam logic [1:0] OP_HDR_OK  = 2'd0;
    localparam logic [1:0] OP_PAYLOAD = 2'd1;
    localparam logic [1:0] OP_HDR_ERR = 2'd2;
    localparam logic [1:0] OP_FAILED  = 2'd3;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } tfd_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  msg_type;
        logic [63:0] sequence_res;
        logic [31:0] payload_length;
        logic [7:0]  payload_byte;
        logic [2:0]  error_code;
        logic        last;
    } tfd_out_t;

    typedef struct packed {
        logic [7:0]  msg_type;
        logic [63:0] sequence_num;
        logic [31:0] length;
    } tfd_hdr_t;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] code;
        logic [7:0] data;
        logic       last;
        tfd_hdr_t   hdr;
    } tfd_op_t;

    typedef struct packed {
        logic    empty;
        tfd_op_t head;
    } tfd_q_rd_t;

endpackage

`default_nettype wire

/* rtl/tfd_front.sv */
// front end: configuration, header gathering, header checks and byte classification
`default_nettype none

module tfd_front
    import tfd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire tfd_in_t               in_data,
    input  wire logic                  q_full,
    output logic                       q_push,
    output tfd_op_t                    q_wdata
);

    logic [31:0]         magic_reg;
    logic [7:0]          version_reg;
    logic [7:0]          type_min_reg;
    logic [7:0]          type_max_reg;
    logic [31:0]         max_payload_reg;

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [31:0]         remaining_reg, remaining_next;
    logic                in_payload_reg, in_payload_next;
    logic                failed_reg, failed_next;
    logic [HDR_BITS-1:0] hdr_bytes_reg;
    logic [HDR_BITS-1:0] assembled;
    logic                accept;
    logic                shift_en;

    logic [31:0]         f_magic;
    logic [7:0]          f_version;
    logic [7:0]          f_type;
    logic [15:0]         f_flags;
    logic [31:0]         f_len;
    logic [63:0]         f_seq;
    logic                hdr_bad;
    logic [2:0]          hdr_code;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg       <= '0;
            version_reg     <= 8'd1;
            type_min_reg    <= 8'd1;
            type_max_reg    <= 8'd255;
            max_payload_reg <= 32'd65535;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAGIC:       magic_reg       <= cfg_data;
                CFG_VERSION:     version_reg     <= cfg_data[7:0];
                CFG_TYPE_MIN:    type_min_reg    <= cfg_data[7:0];
                CFG_TYPE_MAX:    type_max_reg    <= cfg_data[7:0];
                CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // header bytes shift in at the low end, byte 0 ends up on top
    assign assembled = {hdr_bytes_reg[HDR_BITS-9:0], in_data.data_byte};
    assign f_magic   = assembled[159:128];
    assign f_version = assembled[127:120];
    assign f_type    = assembled[119:112];
    assign f_flags   = assembled[111:96];
    assign f_len     = assembled[95:64];
    assign f_seq     = assembled[63:0];

    always_comb
    begin
        hdr_bad  = 1'b1;
        hdr_code = ERR_MAGIC;
        if (f_magic != magic_reg)
            hdr_code = ERR_MAGIC;
        else if (f_version != version_reg)
            hdr_code = ERR_VERSION;
        else if (f_type < type_min_reg || f_type > type_max_reg)
            hdr_code = ERR_TYPE;
        else if (f_flags != 16'd0)
            hdr_code = ERR_FLAGS;
        else if (f_len > max_payload_reg)
            hdr_code = ERR_TOO_LARGE;
        else
            hdr_bad = 1'b0;
    end

    always_comb
    begin
        pos_next        = pos_reg;
        remaining_next  = remaining_reg;
        in_payload_next = in_payload_reg;
        failed_next     = failed_reg;
        shift_en        = 1'b0;
        q_push          = 1'b0;
        q_wdata         = '0;
        if (accept)
        begin
            if (in_data.mode)
            begin
                pos_next        = '0;
                remaining_next  = '0;
                in_payload_next = 1'b0;
                failed_next     = 1'b0;
            end
            else if (failed_reg)
            begin
                q_push       = 1'b1;
                q_wdata.op   = OP_FAILED;
                q_wdata.code = ERR_FAILED;
            end
            else if (in_payload_reg)
            begin
                remaining_next = remaining_reg - 32'd1;
                if (remaining_reg == 32'd1)
                    in_payload_next = 1'b0;
                q_push       = 1'b1;
                q_wdata.op   = OP_PAYLOAD;
                q_wdata.data = in_data.data_byte;
                q_wdata.last = (remaining_reg == 32'd1);
            end
            else
            begin
                shift_en = 1'b1;
                if (pos_reg == POS_LAST)
                begin
                    pos_next                 = '0;
                    q_push                   = 1'b1;
                    q_wdata.hdr.msg_type     = f_type;
                    q_wdata.hdr.sequence_num = f_seq;
                    q_wdata.hdr.length       = f_len;
                    if (hdr_bad)
                    begin
                        failed_next  = 1'b1;
                        q_wdata.op   = OP_HDR_ERR;
                        q_wdata.code = hdr_code;
                    end
                    else
                    begin
                        remaining_next  = f_len;
                        in_payload_next = (f_len != 32'd0);
                        q_wdata.op      = OP_HDR_OK;
                        q_wdata.last    = (f_len == 32'd0);
                    end
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            remaining_reg  <= '0;
            in_payload_reg <= 1'b0;
            failed_reg     <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            remaining_reg  <= remaining_next;
            in_payload_reg <= in_payload_next;
            failed_reg     <= failed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
            hdr_bytes_reg <= assembled;
    end

    a_fail_excl: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |-> !in_payload_reg)
        else $error("payload phase active while failed");

    a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (remaining_reg != 32'd0))
        else $error("payload phase with nothing remaining");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("header position out of range");

endmodule

`default_nettype wire

/* rtl/tfd_queue.sv */
// short op queue between front end and back end
`default_nettype none

module tfd_queue
    import tfd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire tfd_op_t wdata,
    input  wire logic    pop,
    output logic         full,
    output tfd_q_rd_t    rd
);

    tfd_op_t         entry_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_CW-1:0] count_reg;
    logic            do_pop;

    assign full     = (count_reg == Q_CW'(Q_DEPTH));
    assign rd.empty = (count_reg == '0);
    assign rd.head  = entry_reg[rd_ptr_reg];
    assign do_pop   = pop && !rd.empty;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + Q_AW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + Q_AW'(1);
            if (push && !do_pop)
                count_reg <= count_reg + Q_CW'(1);
            else if (!push && do_pop)
                count_reg <= count_reg - Q_CW'(1);
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CW'(Q_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

/* rtl/tfd_back.sv */
// back end: frame context and result output register
`default_nettype none

module tfd_back
    import tfd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire tfd_q_rd_t rd,
    output logic           pop,
    output logic           out_valid,
    input  wire logic      out_stall,
    output tfd_out_t       out_data
);

    tfd_hdr_t ctx_reg;
    tfd_out_t res_reg, res_next;
    logic     valid_reg;
    logic     load;

    assign load      = !rd.empty && (!valid_reg || !out_stall);
    assign pop       = load;
    assign out_valid = valid_reg;
    assign out_data  = res_reg;

    always_comb
    begin
        res_next = '0;
        case (rd.head.op)
            OP_HDR_OK:
            begin
                res_next.kind           = KIND_HEADER;
                res_next.msg_type       = rd.head.hdr.msg_type;
                res_next.sequence_res   = rd.head.hdr.sequence_num;
                res_next.payload_length = rd.head.hdr.length;
                res_next.last           = rd.head.last;
            end
            OP_HDR_ERR:
            begin
                res_next.kind           = KIND_ERROR;
                res_next.msg_type       = rd.head.hdr.msg_type;
                res_next.sequence_res   = rd.head.hdr.sequence_num;
                res_next.payload_length = rd.head.hdr.length;
                res_next.error_code     = rd.head.code;
            end
            OP_PAYLOAD:
            begin
                res_next.kind           = KIND_PAYLOAD;
                res_next.msg_type       = ctx_reg.msg_type;
                res_next.sequence_res   = ctx_reg.sequence_num;
                res_next.payload_length = ctx_reg.length;
                res_next.payload_byte   = rd.head.data;
                res_next.last           = rd.head.last;
            end
            OP_FAILED:
            begin
                res_next.kind       = KIND_ERROR;
                res_next.error_code = ERR_FAILED;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    // header context kept for the payload results that follow
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
            if (rd.head.op == OP_HDR_OK || rd.head.op == OP_HDR_ERR)
                ctx_reg <= rd.head.hdr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && res_reg.kind == KIND_PAYLOAD) |-> (res_reg.error_code == ERR_MAGIC))
        else $error("payload result with error code");

endmodule

`default_nettype wire

/* rtl/tunnel_frame_deframer.sv */
// top level of the tunnel frame deframer
// throughput: one byte transfer per clock while in_stall (queue full) is low, set by the front end state update
// a result passes through an op queue entry and then the back end result register before out_valid shows it
// header checks run in the cycle of the twentieth header byte, payload bytes pass straight on
// reset: asynchronous active low, control and config registers return to defaults and the decoder to header start
`default_nettype none

module tunnel_frame_deframer
    import tfd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire tfd_in_t               in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output tfd_out_t                   out_data
);

    logic      q_full;
    logic      q_push;
    logic      q_pop;
    tfd_op_t   q_wdata;
    tfd_q_rd_t q_rd;

    tfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    tfd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .full  (q_full),
        .rd    (q_rd)
    );

    tfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd        (q_rd),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
